// File: hw/rtl/wts_pkg.sv
// Weekly thermostat schedule: shared types, sizes and codes.
// Used by wts_ctrl, wts_dpath and weekly_thermostat_schedule_top.
`timescale 1ns / 1ps

package wts_pkg;

  localparam int BANDS_PER_DAY = 8;
  localparam int DAYS          = 7;
  localparam int SLOTS         = DAYS * BANDS_PER_DAY;

  localparam int DAY_W    = 3;
  localparam int MINUTE_W = 11;
  localparam int TEMP_W   = 16;
  localparam int RULE_W   = 2;
  localparam int SLOT_W   = (BANDS_PER_DAY > 1) ? $clog2(BANDS_PER_DAY) : 1;
  localparam int CNT_W    = $clog2(BANDS_PER_DAY + 1);
  localparam int ADDR_W   = $clog2(SLOTS);
  localparam int DIDX_W   = $clog2(DAYS);

  typedef logic [DAY_W-1:0]           day_t;
  typedef logic [MINUTE_W-1:0]        minute_t;
  typedef logic signed [TEMP_W-1:0]   temp_t;
  typedef logic [RULE_W-1:0]          rule_code_t;
  typedef logic [SLOT_W-1:0]          slot_t;
  typedef logic [CNT_W-1:0]           count_t;
  typedef logic [ADDR_W-1:0]          addr_t;

  localparam temp_t HIGH_MARGIN = 16'sd80;
  localparam temp_t TEMP_MAX    = 16'sh7FFF;

  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_CHECK = 1'b1;

  localparam logic STATUS_OK     = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;

  localparam rule_code_t RULE_MIN = 2'd0;
  localparam rule_code_t RULE_AVG = 2'd1;
  localparam rule_code_t RULE_MAX = 2'd2;

  typedef struct packed {
    minute_t    band_end;
    temp_t      band_low;
    temp_t      band_high;
    rule_code_t band_rule;
  } band_t;

  typedef struct packed {
    logic accept;
    logic dispatch;
    logic add_check;
    logic scan;
    logic res_clear;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic command;
    logic skip_check;
    logic scan_hit;
    logic out_free;
  } dp_status_t;

endpackage

// File: hw/rtl/wts_ctrl.sv
// Weekly thermostat schedule controller: one-hot sequencer for add and check.
// Depends on wts_pkg; drives commands into wts_dpath.
`timescale 1ns / 1ps

module wts_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  wts_pkg::dp_status_t sts,
  output wts_pkg::ctrl_cmd_t  cmd
);
  import wts_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_DISPATCH = 5'b00010,
    S_ADD_CHK  = 5'b00100,
    S_SCAN     = 5'b01000,
    S_DONE     = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.accept = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        cmd.dispatch = 1'b1;
        if (sts.command == CMD_ADD) begin
          state_next = S_ADD_CHK;
        end else if (sts.skip_check) begin
          cmd.res_clear = 1'b1;
          state_next    = S_DONE;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_ADD_CHK: begin
        cmd.add_check = 1'b1;
        state_next    = S_DONE;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_hit) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign req_stall = (state != S_IDLE);

  a_accept_only_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> state == S_DISPATCH)
    else $error("accept did not move to dispatch");

  a_load_returns_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> !req_stall)
    else $error("result load did not free the request channel");

  a_scan_only_check: assert property (@(posedge clk) disable iff (rst)
    cmd.scan |-> sts.command == CMD_CHECK)
    else $error("scan on an add transaction");

endmodule

// File: hw/rtl/wts_dpath.sv
// Weekly thermostat schedule datapath: band memory, per-day counts, compare
// and result registers. Depends on wts_pkg; driven by wts_ctrl commands.
`timescale 1ns / 1ps

module wts_dpath (
  input  logic                clk,
  input  logic                rst,
  input  wts_pkg::ctrl_cmd_t  cmd,
  output wts_pkg::dp_status_t sts,
  input  logic                command,
  input  wts_pkg::day_t       day,
  input  wts_pkg::minute_t    minute_of_day,
  input  wts_pkg::temp_t      band_low_temp,
  input  wts_pkg::temp_t      band_high_temp,
  input  wts_pkg::rule_code_t target_mode,
  input  wts_pkg::temp_t      coldest_reading,
  input  wts_pkg::temp_t      warmest_reading,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output logic                status,
  output logic                heat_request
);
  import wts_pkg::*;

  // latched transaction
  logic       cmd_q;
  day_t       day_q;
  minute_t    minute_q;
  temp_t      low_q;
  temp_t      high_q;
  rule_code_t rule_q;
  temp_t      cold_q;
  temp_t      warm_q;

  band_t  mem [SLOTS];
  band_t  rd_data;
  addr_t  rd_addr;
  addr_t  wr_addr;
  logic   wr_en;

  count_t used [DAYS];
  count_t n;
  logic   day_ok;
  logic [DIDX_W-1:0] day_idx;
  addr_t  base;
  slot_t  last_slot;

  slot_t  issue_slot;
  slot_t  rd_slot;
  logic   rd_valid;

  logic   add_ok;
  logic   scan_hit;
  logic   heat_sel;
  temp_t  high_fixed;
  logic signed [TEMP_W:0] high_sum;

  logic   res_status;
  logic   res_heat;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_q    <= CMD_ADD;
      day_q    <= '0;
      minute_q <= '0;
      low_q    <= '0;
      high_q   <= '0;
      rule_q   <= RULE_MIN;
      cold_q   <= '0;
      warm_q   <= '0;
    end else if (cmd.accept) begin
      cmd_q    <= command;
      day_q    <= day;
      minute_q <= minute_of_day;
      low_q    <= band_low_temp;
      high_q   <= band_high_temp;
      rule_q   <= target_mode;
      cold_q   <= coldest_reading;
      warm_q   <= warmest_reading;
    end
  end

  assign day_ok    = (day_q >= DAY_W'(1)) && (day_q <= DAY_W'(DAYS));
  assign day_idx   = DIDX_W'(day_q - DAY_W'(1));
  assign n         = day_ok ? used[day_idx] : '0;
  assign base      = ADDR_W'(day_idx) * ADDR_W'(BANDS_PER_DAY);
  assign last_slot = SLOT_W'(n - CNT_W'(1));

  assign rd_addr = cmd.scan ? (base + ADDR_W'(issue_slot)) : (base + ADDR_W'(last_slot));
  assign wr_addr = base + ADDR_W'(n[SLOT_W-1:0]);

  // widen the band when high does not exceed low
  assign high_sum   = {low_q[TEMP_W-1], low_q} + (TEMP_W+1)'(HIGH_MARGIN);
  always_comb begin
    if (high_q > low_q) begin
      high_fixed = high_q;
    end else if (high_sum > (TEMP_W+1)'(TEMP_MAX)) begin
      high_fixed = TEMP_MAX;
    end else begin
      high_fixed = high_sum[TEMP_W-1:0];
    end
  end

  assign add_ok = day_ok && (n < CNT_W'(BANDS_PER_DAY)) &&
                  ((n == '0) || (minute_q > rd_data.band_end));
  assign wr_en  = cmd.add_check && add_ok;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= '{band_end: minute_q, band_low: low_q,
                        band_high: high_fixed, band_rule: rule_q};
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DAYS; i++) begin
        used[i] <= '0;
      end
    end else if (wr_en) begin
      used[day_idx] <= n + CNT_W'(1);
    end
  end

  // scan: issue one read per cycle, evaluate the previous one
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else if (cmd.dispatch) begin
      rd_valid <= 1'b0;
    end else if (cmd.scan) begin
      rd_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.dispatch) begin
      issue_slot <= '0;
    end else if (cmd.scan) begin
      issue_slot <= issue_slot + SLOT_W'(1);
      rd_slot    <= issue_slot;
    end
  end

  assign scan_hit = rd_valid && ((rd_data.band_end > minute_q) || (rd_slot == last_slot));

  always_comb begin
    case (rd_data.band_rule)
      RULE_MIN: heat_sel = warm_q < rd_data.band_low;
      RULE_AVG: heat_sel = cold_q < rd_data.band_low;
      RULE_MAX: heat_sel = warm_q < rd_data.band_high;
      default:  heat_sel = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.add_check) begin
      res_status <= add_ok ? STATUS_OK : STATUS_REJECT;
      res_heat   <= 1'b0;
    end else if (cmd.res_clear) begin
      res_status <= STATUS_OK;
      res_heat   <= 1'b0;
    end else if (cmd.scan && scan_hit) begin
      res_status <= STATUS_OK;
      res_heat   <= heat_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.out_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status       <= res_status;
      heat_request <= res_heat;
    end
  end

  assign sts.command    = cmd_q;
  assign sts.skip_check = !day_ok || (n == '0);
  assign sts.scan_hit   = scan_hit;
  assign sts.out_free   = !rsp_valid || !rsp_stall;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    n <= CNT_W'(BANDS_PER_DAY))
    else $error("band count above capacity");

  a_hit_in_range: assert property (@(posedge clk) disable iff (rst)
    (cmd.scan && scan_hit) |-> (CNT_W'(rd_slot) < n))
    else $error("scan selected a band past the day's count");

  a_commit_counts: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> n == $past(n) + CNT_W'(1))
    else $error("accepted add did not advance the count");

  a_reject_holds: assert property (@(posedge clk) disable iff (rst)
    (cmd.add_check && !add_ok) |=> n == $past(n))
    else $error("rejected add changed the count");

endmodule

// File: hw/rtl/weekly_thermostat_schedule_top.sv
// Weekly thermostat schedule top level.
// Depends on wts_pkg; instantiates wts_ctrl and wts_dpath.
//
// Usage:
//   Request channel (req_valid / req_stall) carries one transaction: an add
//   (append a band to a day) or a check (heat request for a day and minute).
//   Response channel (rsp_valid / rsp_stall) returns status and heat_request,
//   one response per request, in order.
// Steps after acceptance: dispatch, then the add check for an add or the band
//   scan from band 0 for a check (skipped on an empty or invalid day), then
//   the response load. One transaction at a time; a new request is taken
//   after the response is loaded. A check is paced by the band scan, one
//   memory read per cycle through the single read port of the band memory.
// The response register lets the next request be accepted while the
//   previous response still waits; a stalled response holds, and the
//   sequencer waits before loading a new one.
// Reset clears the per-day band counts, the sequencer and rsp_valid; band
//   memory needs no clearing since only counted bands are read.
`timescale 1ns / 1ps

module weekly_thermostat_schedule_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  logic                command,
  input  wts_pkg::day_t       day,
  input  wts_pkg::minute_t    minute_of_day,
  input  wts_pkg::temp_t      band_low_temp,
  input  wts_pkg::temp_t      band_high_temp,
  input  wts_pkg::rule_code_t target_mode,
  input  wts_pkg::temp_t      coldest_reading,
  input  wts_pkg::temp_t      warmest_reading,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output logic                status,
  output logic                heat_request
);
  import wts_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t sts;

  wts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  wts_dpath u_dpath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .command         (command),
    .day             (day),
    .minute_of_day   (minute_of_day),
    .band_low_temp   (band_low_temp),
    .band_high_temp  (band_high_temp),
    .target_mode     (target_mode),
    .coldest_reading (coldest_reading),
    .warmest_reading (warmest_reading),
    .rsp_valid       (rsp_valid),
    .rsp_stall       (rsp_stall),
    .status          (status),
    .heat_request    (heat_request)
  );

endmodule

// File: dv/tb.sv
// Self-checking testbench for weekly_thermostat_schedule_top: directed table, then
// random add/check transactions scored against an in-bench schedule predictor.
// Depends on wts_pkg and the weekly_thermostat_schedule_top RTL.
`timescale 1ns / 1ps

module tb;
  import wts_pkg::*;

  localparam int         ITEMS_RANDOM = 1900;
  localparam int         CYCLE_LIMIT  = 400000;
  localparam int         DRAIN_CYCLES = 24;
  localparam rule_code_t RULE_UNUSED  = 2'd3;
  localparam bit         TYPED        = 1'b1;
  localparam bit         PREDICTED    = 1'b0;

  typedef struct {
    logic       cmd;
    day_t       day;
    minute_t    minute;
    temp_t      lo;
    temp_t      hi;
    rule_code_t mode;
    temp_t      cold;
    temp_t      warm;
    bit         fixed;
    logic       exp_status;
    logic       exp_heat;
  } sched_item_t;

  typedef struct {
    logic status;
    logic heat;
  } sched_rsp_t;

  logic clk = 1'b0;
  logic rst;
  logic req_valid;
  logic req_stall;
  logic rsp_valid;
  logic rsp_stall;
  logic status;
  logic heat_request;

  sched_item_t cur_item;
  sched_item_t dir_q[$];
  sched_rsp_t  sched_rsp_q[$];

  minute_t     sched_end  [SLOTS];
  temp_t       sched_low  [SLOTS];
  temp_t       sched_high [SLOTS];
  rule_code_t  sched_rule [SLOTS];
  int          sched_count[DAYS];

  int          mismatches = 0;
  int unsigned cycle_cnt  = 0;
  bit          quiet      = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  weekly_thermostat_schedule_top u_dut (
    .clk             (clk),
    .rst             (rst),
    .req_valid       (req_valid),
    .req_stall       (req_stall),
    .command         (cur_item.cmd),
    .day             (cur_item.day),
    .minute_of_day   (cur_item.minute),
    .band_low_temp   (cur_item.lo),
    .band_high_temp  (cur_item.hi),
    .target_mode     (cur_item.mode),
    .coldest_reading (cur_item.cold),
    .warmest_reading (cur_item.warm),
    .rsp_valid       (rsp_valid),
    .rsp_stall       (rsp_stall),
    .status          (status),
    .heat_request    (heat_request)
  );

  task automatic log_mismatch(input string what);
    mismatches++;
    $display("[%0t] %s", $time, what);
  endtask

  function automatic int draw_gap();
    return quiet ? 0 : $urandom_range(0, 14);
  endfunction

  // Apply one transaction to the schedule copy and return its response.
  function automatic sched_rsp_t schedule_step(input sched_item_t it);
    sched_rsp_t r;
    int         n, base, sel, hi_sat;
    r.status = STATUS_OK;
    r.heat   = 1'b0;
    if (it.cmd == CMD_ADD) begin
      r.status = STATUS_REJECT;
      if (it.day != 0) begin
        n    = sched_count[it.day - 1];
        base = (it.day - 1) * BANDS_PER_DAY;
        if (n < BANDS_PER_DAY && (n == 0 || it.minute > sched_end[base + n - 1])) begin
          hi_sat = it.hi;
          if (it.hi <= it.lo) begin
            hi_sat = int'(it.lo) + 80;
            if (hi_sat > 32767) hi_sat = 32767;
          end
          sched_end[base + n]     = it.minute;
          sched_low[base + n]     = it.lo;
          sched_high[base + n]    = temp_t'(hi_sat);
          sched_rule[base + n]    = it.mode;
          sched_count[it.day - 1] = n + 1;
          r.status = STATUS_OK;
        end
      end
    end else if (it.day != 0) begin
      n    = sched_count[it.day - 1];
      base = (it.day - 1) * BANDS_PER_DAY;
      if (n > 0) begin
        sel = n - 1;
        for (int i = n - 1; i >= 0; i--) begin
          if (sched_end[base + i] > it.minute) sel = i;
        end
        sel += base;
        case (sched_rule[sel])
          RULE_MIN: r.heat = (it.warm < sched_low[sel]);
          RULE_AVG: r.heat = (it.cold < sched_low[sel]);
          RULE_MAX: r.heat = (it.warm < sched_high[sel]);
          default:  r.heat = 1'b0;
        endcase
      end
    end
    return r;
  endfunction

  function automatic sched_item_t row(input logic c, input int d, input int m, input int lo,
                                      input int hi, input rule_code_t md, input int cold,
                                      input int warm, input bit fx, input logic st,
                                      input logic ht);
    sched_item_t it;
    it.cmd        = c;
    it.day        = day_t'(d);
    it.minute     = minute_t'(m);
    it.lo         = temp_t'(lo);
    it.hi         = temp_t'(hi);
    it.mode       = md;
    it.cold       = temp_t'(cold);
    it.warm       = temp_t'(warm);
    it.fixed      = fx;
    it.exp_status = st;
    it.exp_heat   = ht;
    return it;
  endfunction

  // Mostly well-formed band appends and checks aimed at stored band edges.
  function automatic sched_item_t random_item();
    sched_item_t it;
    int          pick, d, n, base, last, k, step_max;
    temp_t       off;
    it.cmd        = CMD_CHECK;
    it.day        = day_t'($urandom_range(0, 7));
    it.minute     = minute_t'($urandom_range(0, 2047));
    it.lo         = temp_t'($urandom);
    it.hi         = temp_t'($urandom);
    it.mode       = rule_code_t'($urandom_range(0, 3));
    it.cold       = temp_t'($urandom);
    it.warm       = temp_t'($urandom);
    it.fixed      = PREDICTED;
    it.exp_status = STATUS_OK;
    it.exp_heat   = 1'b0;
    pick = $urandom_range(0, 99);
    d    = $urandom_range(1, DAYS);
    n    = sched_count[d - 1];
    base = (d - 1) * BANDS_PER_DAY;
    last = (n > 0) ? int'(sched_end[base + n - 1]) : -1;
    if (pick < 12) begin
      it.cmd = CMD_ADD;
      it.day = day_t'(d);
      if (pick < 8) begin
        if (n == 0) begin
          it.minute = minute_t'($urandom_range(0, 400));
        end else if (last < 2047) begin
          step_max  = (2047 - last < 300) ? 2047 - last : 300;
          it.minute = minute_t'(last + int'($urandom_range(1, step_max)));
        end
        case ($urandom_range(0, 7))
          0: begin
            it.lo = temp_t'(32767 - int'($urandom_range(0, 120)));
            it.hi = it.lo;
          end
          1, 2: it.hi = it.lo - temp_t'($urandom_range(0, 2));
          default: ;
        endcase
      end else if (pick == 8) begin
        it.day = '0;
      end else if (n > 0) begin
        it.minute = minute_t'(last - int'($urandom_range(0, last)));
      end
    end else begin
      it.day = (pick < 96) ? day_t'(d) : day_t'(0);
      if (n > 0 && $urandom_range(0, 1) == 1) begin
        k         = $urandom_range(0, n - 1);
        it.minute = sched_end[base + k] + minute_t'($urandom_range(0, 2)) - minute_t'(1);
        off       = temp_t'($urandom_range(0, 2)) - temp_t'(1);
        it.cold   = sched_low[base + k] + off;
        off       = temp_t'($urandom_range(0, 2)) - temp_t'(1);
        it.warm   = ($urandom_range(0, 1) == 1) ? sched_low[base + k] + off
                                                : sched_high[base + k] + off;
      end
    end
    return it;
  endfunction

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("weekly_thermostat_schedule_top: mismatch");
      $finish;
    end
  end

  always @(posedge clk) begin : score
    sched_rsp_t want;
    if (!rst) begin
      if (req_valid && !req_stall) begin
        want = schedule_step(cur_item);
        if (cur_item.fixed) begin
          want.status = cur_item.exp_status;
          want.heat   = cur_item.exp_heat;
        end
        sched_rsp_q.push_back(want);
      end
      if (rsp_valid && !rsp_stall) begin
        if (sched_rsp_q.size() == 0) begin
          log_mismatch("response transaction with no request outstanding");
        end else begin
          want = sched_rsp_q.pop_front();
          if (status !== want.status)
            log_mismatch($sformatf("status %b, expected %b", status, want.status));
          if (heat_request !== want.heat)
            log_mismatch($sformatf("heat_request %b, expected %b", heat_request, want.heat));
        end
      end
    end
  end

  initial begin : rsp_side
    int hold;
    rsp_stall = 1'b0;
    @(negedge clk);
    forever begin
      hold = draw_gap();
      if (hold > 0) begin
        rsp_stall = 1'b1;
        repeat (hold) @(negedge clk);
      end
      rsp_stall = 1'b0;
      do @(posedge clk); while (!rsp_valid);
      @(negedge clk);
    end
  end

  initial begin : req_side
    int gap, total;
    rst       = 1'b1;
    req_valid = 1'b0;
    cur_item  = row(CMD_ADD, 0, 0, 0, 0, RULE_MIN, 0, 0, PREDICTED, STATUS_OK, 1'b0);

    dir_q.push_back(row(CMD_CHECK, 1, 0, 0, 0, RULE_MIN, 0, 0, TYPED, STATUS_OK, 1'b0));
    dir_q.push_back(row(CMD_CHECK, 0, 100, 0, 0, RULE_MIN, -32768, -32768,
                        TYPED, STATUS_OK, 1'b0));
    dir_q.push_back(row(CMD_ADD, 0, 100, 0, 10, RULE_MIN, 0, 0, TYPED, STATUS_REJECT, 1'b0));
    dir_q.push_back(row(CMD_ADD, 7, 2047, -32768, 32767, RULE_MIN, 0, 0,
                        TYPED, STATUS_OK, 1'b0));
    dir_q.push_back(row(CMD_ADD, 7, 2047, 0, 1, RULE_MAX, 0, 0, TYPED, STATUS_REJECT, 1'b0));
    dir_q.push_back(row(CMD_CHECK, 7, 2047, 0, 0, RULE_MIN, 32767, -32768,
                        TYPED, STATUS_OK, 1'b0));
    dir_q.push_back(row(CMD_ADD, 1, 0, 32767, 32767, RULE_MAX, 0, 0, TYPED, STATUS_OK, 1'b0));
    dir_q.push_back(row(CMD_CHECK, 1, 0, 0, 0, RULE_MIN, 0, 32766, PREDICTED, STATUS_OK, 1'b0));
    dir_q.push_back(row(CMD_ADD, 1, 0, 0, 10, RULE_MIN, 0, 0, TYPED, STATUS_REJECT, 1'b0));
    dir_q.push_back(row(CMD_ADD, 1, 100, -100, -200, RULE_AVG, 0, 0, TYPED, STATUS_OK, 1'b0));
    dir_q.push_back(row(CMD_ADD, 1, 200, 0, 10, RULE_UNUSED, 0, 0, TYPED, STATUS_OK, 1'b0));
    dir_q.push_back(row(CMD_ADD, 1, 1439, 32700, 0, RULE_MIN, 0, 0, TYPED, STATUS_OK, 1'b0));
    dir_q.push_back(row(CMD_ADD, 1, 1440, -5, 5, RULE_MAX, 0, 0, TYPED, STATUS_OK, 1'b0));
    dir_q.push_back(row(CMD_ADD, 1, 1441, 0, 0, RULE_MAX, 0, 0, TYPED, STATUS_OK, 1'b0));
    dir_q.push_back(row(CMD_ADD, 1, 2000, 1, 2, RULE_MIN, 0, 0, TYPED, STATUS_OK, 1'b0));
    dir_q.push_back(row(CMD_ADD, 1, 2046, -32768, -32768, RULE_AVG, 0, 0,
                        TYPED, STATUS_OK, 1'b0));
    dir_q.push_back(row(CMD_ADD, 1, 2047, 0, 10, RULE_MIN, 0, 0, TYPED, STATUS_REJECT, 1'b0));
    dir_q.push_back(row(CMD_CHECK, 1, 2047, 0, 0, RULE_MIN, -32768, 0,
                        PREDICTED, STATUS_OK, 1'b0));
    dir_q.push_back(row(CMD_CHECK, 1, 50, 0, 0, RULE_MIN, -101, 0, PREDICTED, STATUS_OK, 1'b0));
    dir_q.push_back(row(CMD_CHECK, 1, 150, 0, 0, RULE_MIN, -32768, -32768,
                        PREDICTED, STATUS_OK, 1'b0));
    dir_q.push_back(row(CMD_CHECK, 1, 1000, 0, 0, RULE_MIN, 0, 32699,
                        PREDICTED, STATUS_OK, 1'b0));
    dir_q.push_back(row(CMD_CHECK, 1, 1440, 0, 0, RULE_MIN, 0, 79, PREDICTED, STATUS_OK, 1'b0));
    dir_q.push_back(row(CMD_CHECK, 1, 2046, 0, 0, RULE_MIN, -32767, 0,
                        PREDICTED, STATUS_OK, 1'b0));

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst   = 1'b0;
    total = dir_q.size() + ITEMS_RANDOM;
    for (int k = 0; k < total; k++) begin
      if (k % 120 == 0) quiet = ($urandom_range(0, 3) == 0);
      gap = draw_gap();
      if (gap > 0) begin
        req_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      cur_item  = (k < dir_q.size()) ? dir_q[k] : random_item();
      req_valid = 1'b1;
      do @(posedge clk); while (req_stall);
      @(negedge clk);
    end
    req_valid = 1'b0;

    while (sched_rsp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("weekly_thermostat_schedule_top: match");
    end else begin
      $display("weekly_thermostat_schedule_top: mismatch");
    end
    $finish;
  end

endmodule

// File: weekly_thermostat_schedule_top.f
hw/rtl/wts_pkg.sv
hw/rtl/wts_ctrl.sv
hw/rtl/wts_dpath.sv
hw/rtl/weekly_thermostat_schedule_top.sv
dv/tb.sv
